/* rtl/mpi_pkg.sv */
// Types, constants and the micro-program of the midpoint preintegration block.
// Used by the multiply-accumulate unit and the top level; depends on nothing.
`timescale 1ns / 1ps

package mpi_pkg;

  localparam int NUM_UOPS = 59;
  localparam int PC_W = 6;
  localparam int ACC_W = 66;

  localparam logic [2:0] CFG_ACCEL_BIAS_X = 3'd0;
  localparam logic [2:0] CFG_ACCEL_BIAS_Y = 3'd1;
  localparam logic [2:0] CFG_ACCEL_BIAS_Z = 3'd2;
  localparam logic [2:0] CFG_GYRO_BIAS_X = 3'd3;
  localparam logic [2:0] CFG_GYRO_BIAS_Y = 3'd4;
  localparam logic [2:0] CFG_GYRO_BIAS_Z = 3'd5;
  localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd6;

  localparam logic [23:0] PERIOD_RESET = 24'd83886;
  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
  localparam logic KIND_START = 1'b0;

  typedef enum logic [3:0] {
    OPD_T, OPD_T2, OPD_ONE, OPD_AVG, OPD_Q, OPD_NQ,
    OPD_H, OPD_C0, OPD_C1, OPD_TV, OPD_S, OPD_V
  } opd_t;

  typedef enum logic [3:0] {
    PST_NONE, PST_T2, PST_H, PST_NQ, PST_TV, PST_S, PST_PT, PST_POS, PST_VEL
  } pst_t;

  typedef struct packed {
    opd_t       a;
    logic [1:0] ai;
    opd_t       b;
    logic [1:0] bi;
    logic       neg;
    logic       sh2;
    logic       first;
    pst_t       post;
    logic [1:0] pi;
  } uop_t;

  typedef struct packed {
    logic valid;
    uop_t u;
  } stage_t;

  function automatic uop_t mk(input opd_t a, input int ai, input opd_t b, input int bi,
                              input logic neg, input logic sh2, input logic first,
                              input pst_t post, input int pi);
    uop_t u;
    u.a = a;
    u.ai = 2'(ai);
    u.b = b;
    u.bi = 2'(bi);
    u.neg = neg;
    u.sh2 = sh2;
    u.first = first;
    u.post = post;
    u.pi = 2'(pi);
    return u;
  endfunction

  // Rotation of a vector by a quaternion: cross product first, then the
  // scalar and cross terms added into the acceleration sum.
  function automatic uop_t rot_uop(input opd_t qk, input opd_t vk, input int k);
    uop_t u;
    case (k)
      0:  u = mk(qk, 2, vk, 2, 1'b0, 1'b0, 1'b1, PST_NONE, 0);
      1:  u = mk(qk, 3, vk, 1, 1'b1, 1'b0, 1'b0, PST_TV, 0);
      2:  u = mk(qk, 3, vk, 0, 1'b0, 1'b0, 1'b1, PST_NONE, 0);
      3:  u = mk(qk, 1, vk, 2, 1'b1, 1'b0, 1'b0, PST_TV, 1);
      4:  u = mk(qk, 1, vk, 1, 1'b0, 1'b0, 1'b1, PST_NONE, 0);
      5:  u = mk(qk, 2, vk, 0, 1'b1, 1'b0, 1'b0, PST_TV, 2);
      6:  u = mk(qk, 0, OPD_TV, 0, 1'b0, 1'b0, 1'b1, PST_S, 0);
      7:  u = mk(qk, 2, OPD_TV, 2, 1'b0, 1'b0, 1'b1, PST_NONE, 0);
      8:  u = mk(qk, 3, OPD_TV, 1, 1'b1, 1'b0, 1'b0, PST_S, 0);
      9:  u = mk(qk, 0, OPD_TV, 1, 1'b0, 1'b0, 1'b1, PST_S, 1);
      10: u = mk(qk, 3, OPD_TV, 0, 1'b0, 1'b0, 1'b1, PST_NONE, 0);
      11: u = mk(qk, 1, OPD_TV, 2, 1'b1, 1'b0, 1'b0, PST_S, 1);
      12: u = mk(qk, 0, OPD_TV, 2, 1'b0, 1'b0, 1'b1, PST_S, 2);
      13: u = mk(qk, 1, OPD_TV, 1, 1'b0, 1'b0, 1'b1, PST_NONE, 0);
      default: u = mk(qk, 2, OPD_TV, 0, 1'b1, 1'b0, 1'b0, PST_S, 2);
    endcase
    return u;
  endfunction

  function automatic uop_t mpi_uop(input logic [PC_W-1:0] pc);
    int p;
    uop_t u;
    p = int'(pc);
    case (p)
      0:  u = mk(OPD_T, 0, OPD_T, 0, 1'b0, 1'b0, 1'b1, PST_T2, 0);
      1:  u = mk(OPD_AVG, 0, OPD_T, 0, 1'b0, 1'b0, 1'b1, PST_H, 0);
      2:  u = mk(OPD_AVG, 1, OPD_T, 0, 1'b0, 1'b0, 1'b1, PST_H, 1);
      3:  u = mk(OPD_AVG, 2, OPD_T, 0, 1'b0, 1'b0, 1'b1, PST_H, 2);
      4:  u = mk(OPD_Q, 0, OPD_ONE, 0, 1'b0, 1'b1, 1'b1, PST_NONE, 0);
      5:  u = mk(OPD_Q, 1, OPD_H, 0, 1'b1, 1'b1, 1'b0, PST_NONE, 0);
      6:  u = mk(OPD_Q, 2, OPD_H, 1, 1'b1, 1'b1, 1'b0, PST_NONE, 0);
      7:  u = mk(OPD_Q, 3, OPD_H, 2, 1'b1, 1'b1, 1'b0, PST_NQ, 0);
      8:  u = mk(OPD_Q, 0, OPD_H, 0, 1'b0, 1'b1, 1'b1, PST_NONE, 0);
      9:  u = mk(OPD_Q, 1, OPD_ONE, 0, 1'b0, 1'b1, 1'b0, PST_NONE, 0);
      10: u = mk(OPD_Q, 2, OPD_H, 2, 1'b0, 1'b1, 1'b0, PST_NONE, 0);
      11: u = mk(OPD_Q, 3, OPD_H, 1, 1'b1, 1'b1, 1'b0, PST_NQ, 1);
      12: u = mk(OPD_Q, 0, OPD_H, 1, 1'b0, 1'b1, 1'b1, PST_NONE, 0);
      13: u = mk(OPD_Q, 1, OPD_H, 2, 1'b1, 1'b1, 1'b0, PST_NONE, 0);
      14: u = mk(OPD_Q, 2, OPD_ONE, 0, 1'b0, 1'b1, 1'b0, PST_NONE, 0);
      15: u = mk(OPD_Q, 3, OPD_H, 0, 1'b0, 1'b1, 1'b0, PST_NQ, 2);
      16: u = mk(OPD_Q, 0, OPD_H, 2, 1'b0, 1'b1, 1'b1, PST_NONE, 0);
      17: u = mk(OPD_Q, 1, OPD_H, 1, 1'b0, 1'b1, 1'b0, PST_NONE, 0);
      18: u = mk(OPD_Q, 2, OPD_H, 0, 1'b1, 1'b1, 1'b0, PST_NONE, 0);
      19: u = mk(OPD_Q, 3, OPD_ONE, 0, 1'b0, 1'b1, 1'b0, PST_NQ, 3);
      default: begin
        if (p < 35) begin
          u = rot_uop(OPD_Q, OPD_C0, p - 20);
        end else if (p < 50) begin
          u = rot_uop(OPD_NQ, OPD_C1, p - 35);
        end else if (p < 53) begin
          u = mk(OPD_V, p - 50, OPD_T, 0, 1'b0, 1'b0, 1'b1, PST_PT, p - 50);
        end else if (p < 56) begin
          u = mk(OPD_T2, 0, OPD_S, p - 53, 1'b0, 1'b0, 1'b1, PST_POS, p - 53);
        end else if (p < NUM_UOPS) begin
          u = mk(OPD_T, 0, OPD_S, p - 56, 1'b0, 1'b0, 1'b1, PST_VEL, p - 56);
        end else begin
          u = mk(OPD_ONE, 0, OPD_ONE, 0, 1'b0, 1'b0, 1'b1, PST_NONE, 0);
        end
      end
    endcase
    return u;
  endfunction

  // Adds half an LSB and shifts right with floor; n is always a constant.
  function automatic logic signed [ACC_W-1:0] rnd_shift(input logic signed [ACC_W-1:0] v,
                                                        input int n);
    logic signed [ACC_W-1:0] half;
    half = 66'sd1 <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

/* rtl/mpi_if.sv */
// Request channels of the midpoint preintegration block: IMU samples in,
// preintegrated deltas and rotation out. Depends on nothing.
`timescale 1ns / 1ps

interface mpi_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [23:0] accel_x;
  logic signed [23:0] accel_y;
  logic signed [23:0] accel_z;
  logic signed [23:0] gyro_x;
  logic signed [23:0] gyro_y;
  logic signed [23:0] gyro_z;

  modport source(output valid, kind, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 input ready);
  modport sink(input valid, kind, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
               output ready);
endinterface

interface mpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_delta_x;
  logic signed [31:0] pos_delta_y;
  logic signed [31:0] pos_delta_z;
  logic signed [31:0] vel_delta_x;
  logic signed [31:0] vel_delta_y;
  logic signed [31:0] vel_delta_z;
  logic signed [31:0] rot_w;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;

  modport source(output valid, pos_delta_x, pos_delta_y, pos_delta_z, vel_delta_x,
                 vel_delta_y, vel_delta_z, rot_w, rot_x, rot_y, rot_z, input ready);
  modport sink(input valid, pos_delta_x, pos_delta_y, pos_delta_z, vel_delta_x,
               vel_delta_y, vel_delta_z, rot_w, rot_x, rot_y, rot_z, output ready);
endinterface

/* rtl/imu_midpoint_preintegration_top.sv */
// Top level of the midpoint IMU preintegration block: sequencer, state and
// write-back around one shared multiply-accumulate unit.
// Depends on mpi_pkg, mpi_in_if, mpi_out_if and mpi_mac.
//
//   Channel   Direction  Handshake            Payload
//   in_chan   in         valid/ready          kind, accel_x/y/z, gyro_x/y/z
//   out_chan  out        valid/ready          pos_delta, vel_delta, rot_w/x/y/z
//   cfg_*     in         cfg_we, no wait      cfg_idx, cfg_data
//
// A start request goes through ST_OUT to the output register.
// An integrate request passes through ST_PREP, then 59 products on the single 32x32
// multiplier in ST_RUN with a drain after each of the 35 groups that write back a
// result, then the commit and ST_OUT, which loads the output register.
// Input ready is high only while idle; a result waiting in the output register
// delays the output load and so the next acceptance, not the commit.
// Reset is synchronous and restores the bias, period and integration state.
`timescale 1ns / 1ps

module imu_midpoint_preintegration_top (
  input  logic        clk,
  input  logic        rst_n,
  mpi_in_if.sink      in_chan,
  mpi_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [23:0] cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_RUN, ST_OUT} state_t;

  state_t                    state_r;
  logic [mpi_pkg::PC_W-1:0]  pc_r;

  logic signed [23:0] ab_r [3];
  logic signed [23:0] gb_r [3];
  logic [23:0]        per_r;
  logic signed [23:0] prev_a_r [3];
  logic signed [23:0] prev_g_r [3];
  logic signed [23:0] cur_a_r [3];
  logic signed [23:0] cur_g_r [3];
  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] q_r [4];
  logic signed [31:0] nq_r [4];
  logic signed [24:0] avg_r [3];
  logic signed [24:0] c0_r [3];
  logic signed [24:0] c1_r [3];
  logic signed [31:0] h_r [3];
  logic signed [31:0] tv_r [3];
  logic signed [31:0] s_r [3];
  logic signed [33:0] pt_r [3];
  logic signed [31:0] t2_r;
  logic               out_valid_r;
  logic signed [31:0] out_pos_r [3];
  logic signed [31:0] out_vel_r [3];
  logic signed [31:0] out_q_r [4];

  logic signed [23:0] in_a [3];
  logic signed [23:0] in_g [3];
  logic signed [24:0] avg_c [3];
  logic signed [24:0] c0_c [3];
  logic signed [24:0] c1_c [3];

  logic                              in_acc;
  logic                              out_load;
  logic                              issue;
  logic                              run_done;
  mpi_pkg::uop_t                     uop;
  logic signed [31:0]                opa;
  logic signed [31:0]                opb;
  mpi_pkg::stage_t                   mac_s1;
  mpi_pkg::stage_t                   mac_s2;
  logic signed [mpi_pkg::ACC_W-1:0]  acc;
  logic signed [mpi_pkg::ACC_W-1:0]  r15, r24, r25, r26, r28, r29, r30;
  logic signed [31:0]                per_s;

  assign in_a[0] = in_chan.accel_x;
  assign in_a[1] = in_chan.accel_y;
  assign in_a[2] = in_chan.accel_z;
  assign in_g[0] = in_chan.gyro_x;
  assign in_g[1] = in_chan.gyro_y;
  assign in_g[2] = in_chan.gyro_z;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc = in_chan.valid && in_chan.ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_chan.ready);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      avg_c[i] = ((25'(prev_g_r[i]) + 25'(cur_g_r[i])) >>> 1) - 25'(gb_r[i]);
      c0_c[i] = 25'(prev_a_r[i]) - 25'(ab_r[i]);
      c1_c[i] = 25'(cur_a_r[i]) - 25'(ab_r[i]);
    end
  end

  assign uop = mpi_pkg::mpi_uop(pc_r);
  assign per_s = {8'd0, per_r};

  assign issue = (state_r == ST_RUN) && (pc_r != mpi_pkg::PC_W'(mpi_pkg::NUM_UOPS))
              && !(mac_s1.valid && mac_s1.u.post != mpi_pkg::PST_NONE)
              && !(mac_s2.valid && mac_s2.u.post != mpi_pkg::PST_NONE);
  assign run_done = (state_r == ST_RUN) && (pc_r == mpi_pkg::PC_W'(mpi_pkg::NUM_UOPS))
                 && !mac_s1.valid && !mac_s2.valid;

  always_comb begin
    case (uop.a)
      mpi_pkg::OPD_T:   opa = per_s;
      mpi_pkg::OPD_T2:  opa = t2_r;
      mpi_pkg::OPD_ONE: opa = mpi_pkg::Q30_ONE;
      mpi_pkg::OPD_AVG: opa = 32'(avg_r[uop.ai]);
      mpi_pkg::OPD_Q:   opa = q_r[uop.ai];
      mpi_pkg::OPD_NQ:  opa = nq_r[uop.ai];
      mpi_pkg::OPD_H:   opa = h_r[uop.ai];
      mpi_pkg::OPD_C0:  opa = 32'(c0_r[uop.ai]);
      mpi_pkg::OPD_C1:  opa = 32'(c1_r[uop.ai]);
      mpi_pkg::OPD_TV:  opa = tv_r[uop.ai];
      mpi_pkg::OPD_S:   opa = s_r[uop.ai];
      mpi_pkg::OPD_V:   opa = vel_r[uop.ai];
      default:          opa = '0;
    endcase
    case (uop.b)
      mpi_pkg::OPD_T:   opb = per_s;
      mpi_pkg::OPD_T2:  opb = t2_r;
      mpi_pkg::OPD_ONE: opb = mpi_pkg::Q30_ONE;
      mpi_pkg::OPD_AVG: opb = 32'(avg_r[uop.bi]);
      mpi_pkg::OPD_Q:   opb = q_r[uop.bi];
      mpi_pkg::OPD_NQ:  opb = nq_r[uop.bi];
      mpi_pkg::OPD_H:   opb = h_r[uop.bi];
      mpi_pkg::OPD_C0:  opb = 32'(c0_r[uop.bi]);
      mpi_pkg::OPD_C1:  opb = 32'(c1_r[uop.bi]);
      mpi_pkg::OPD_TV:  opb = tv_r[uop.bi];
      mpi_pkg::OPD_S:   opb = s_r[uop.bi];
      mpi_pkg::OPD_V:   opb = vel_r[uop.bi];
      default:          opb = '0;
    endcase
  end

  mpi_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .uop   (uop),
    .opa   (opa),
    .opb   (opb),
    .s1    (mac_s1),
    .s2    (mac_s2),
    .acc   (acc)
  );

  assign r15 = mpi_pkg::rnd_shift(acc, 15);
  assign r24 = mpi_pkg::rnd_shift(acc, 24);
  assign r25 = mpi_pkg::rnd_shift(acc, 25);
  assign r26 = mpi_pkg::rnd_shift(acc, 26);
  assign r28 = mpi_pkg::rnd_shift(acc, 28);
  assign r29 = mpi_pkg::rnd_shift(acc, 29);
  assign r30 = mpi_pkg::rnd_shift(acc, 30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r <= '0;
      per_r <= mpi_pkg::PERIOD_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ab_r[i] <= '0;
        gb_r[i] <= '0;
        prev_a_r[i] <= '0;
        prev_g_r[i] <= '0;
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
      q_r[0] <= mpi_pkg::Q30_ONE;
      q_r[1] <= '0;
      q_r[2] <= '0;
      q_r[3] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          mpi_pkg::CFG_ACCEL_BIAS_X:  ab_r[0] <= cfg_data;
          mpi_pkg::CFG_ACCEL_BIAS_Y:  ab_r[1] <= cfg_data;
          mpi_pkg::CFG_ACCEL_BIAS_Z:  ab_r[2] <= cfg_data;
          mpi_pkg::CFG_GYRO_BIAS_X:   gb_r[0] <= cfg_data;
          mpi_pkg::CFG_GYRO_BIAS_Y:   gb_r[1] <= cfg_data;
          mpi_pkg::CFG_GYRO_BIAS_Z:   gb_r[2] <= cfg_data;
          mpi_pkg::CFG_SAMPLE_PERIOD: per_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_chan.kind == mpi_pkg::KIND_START) begin
              for (int i = 0; i < 3; i++) begin
                prev_a_r[i] <= in_a[i];
                prev_g_r[i] <= in_g[i];
                pos_r[i] <= '0;
                vel_r[i] <= '0;
              end
              q_r[0] <= mpi_pkg::Q30_ONE;
              q_r[1] <= '0;
              q_r[2] <= '0;
              q_r[3] <= '0;
              state_r <= ST_OUT;
            end else begin
              state_r <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          pc_r <= '0;
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          if (issue) begin
            pc_r <= pc_r + 1'b1;
          end
          if (mac_s2.valid) begin
            case (mac_s2.u.post)
              mpi_pkg::PST_T2:  t2_r <= r24[31:0];
              mpi_pkg::PST_H:   h_r[mac_s2.u.pi] <= mpi_pkg::sat32(r15);
              mpi_pkg::PST_NQ:  nq_r[mac_s2.u.pi] <= mpi_pkg::sat32(r28);
              mpi_pkg::PST_TV:  tv_r[mac_s2.u.pi] <= r29[31:0];
              mpi_pkg::PST_S:   s_r[mac_s2.u.pi] <= s_r[mac_s2.u.pi] + r30[31:0];
              mpi_pkg::PST_PT:  pt_r[mac_s2.u.pi] <= pt_r[mac_s2.u.pi] + r24[33:0];
              mpi_pkg::PST_POS: pos_r[mac_s2.u.pi] <=
                                  mpi_pkg::sat32(66'(pt_r[mac_s2.u.pi]) + r26);
              mpi_pkg::PST_VEL: vel_r[mac_s2.u.pi] <=
                                  mpi_pkg::sat32(66'(vel_r[mac_s2.u.pi]) + r25);
              default: ;
            endcase
          end
          if (run_done) begin
            for (int i = 0; i < 4; i++) begin
              q_r[i] <= nq_r[i];
            end
            for (int i = 0; i < 3; i++) begin
              prev_a_r[i] <= cur_a_r[i];
              prev_g_r[i] <= cur_g_r[i];
            end
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end

    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        cur_a_r[i] <= in_a[i];
        cur_g_r[i] <= in_g[i];
      end
    end
    if (state_r == ST_PREP) begin
      for (int i = 0; i < 3; i++) begin
        avg_r[i] <= avg_c[i];
        c0_r[i] <= c0_c[i];
        c1_r[i] <= c1_c[i];
        s_r[i] <= 32'(c0_c[i]) + 32'(c1_c[i]);
        pt_r[i] <= 34'(pos_r[i]);
      end
    end
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        out_pos_r[i] <= pos_r[i];
        out_vel_r[i] <= vel_r[i];
      end
      for (int i = 0; i < 4; i++) begin
        out_q_r[i] <= q_r[i];
      end
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.pos_delta_x = out_pos_r[0];
  assign out_chan.pos_delta_y = out_pos_r[1];
  assign out_chan.pos_delta_z = out_pos_r[2];
  assign out_chan.vel_delta_x = out_vel_r[0];
  assign out_chan.vel_delta_y = out_vel_r[1];
  assign out_chan.vel_delta_z = out_vel_r[2];
  assign out_chan.rot_w = out_q_r[0];
  assign out_chan.rot_x = out_q_r[1];
  assign out_chan.rot_y = out_q_r[2];
  assign out_chan.rot_z = out_q_r[3];

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=>
      (out_chan.valid && $stable(out_chan.pos_delta_x) && $stable(out_chan.rot_w)))
    else $error("pending result changed before it was taken");

  a_group_drained: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> !(mac_s2.valid && mac_s2.u.post != mpi_pkg::PST_NONE))
    else $error("product issued before the previous group was written back");

  a_start_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.kind == mpi_pkg::KIND_START) |=>
      (state_r == ST_OUT && q_r[0] == mpi_pkg::Q30_ONE && pos_r[0] == '0))
    else $error("start request did not give the identity result");

  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= mpi_pkg::PC_W'(mpi_pkg::NUM_UOPS))
    else $error("sequencer ran past the end of the program");
`endif

endmodule

/* rtl/mpi_mac.sv */
// Shared two-stage multiply-accumulate unit: a registered 32x32 signed
// product, then negate, arithmetic shift and accumulate. Depends on mpi_pkg.
`timescale 1ns / 1ps

module mpi_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               issue,
  input  mpi_pkg::uop_t                      uop,
  input  logic signed [31:0]                 opa,
  input  logic signed [31:0]                 opb,
  output mpi_pkg::stage_t                    s1,
  output mpi_pkg::stage_t                    s2,
  output logic signed [mpi_pkg::ACC_W-1:0]   acc
);

  logic                             s1_v_r;
  logic                             s2_v_r;
  mpi_pkg::uop_t                    s1_u_r;
  mpi_pkg::uop_t                    s2_u_r;
  logic signed [63:0]               prod_r;
  logic signed [63:0]               prod_nxt;
  logic signed [mpi_pkg::ACC_W-1:0] acc_r;
  logic signed [mpi_pkg::ACC_W-1:0] pext;
  logic signed [mpi_pkg::ACC_W-1:0] term_neg;
  logic signed [mpi_pkg::ACC_W-1:0] term;
  logic signed [mpi_pkg::ACC_W-1:0] acc_nxt;

  assign prod_nxt = opa * opb;
  assign pext = {{2{prod_r[63]}}, prod_r};
  assign term_neg = s1_u_r.neg ? -pext : pext;
  assign term = s1_u_r.sh2 ? (term_neg >>> 2) : term_neg;
  assign acc_nxt = (s1_u_r.first ? '0 : acc_r) + term;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
    end
    s1_u_r <= uop;
    s2_u_r <= s1_u_r;
    prod_r <= prod_nxt;
    if (s1_v_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign s1 = '{valid: s1_v_r, u: s1_u_r};
  assign s2 = '{valid: s2_v_r, u: s2_u_r};
  assign acc = acc_r;

endmodule

/* dv/imu_midpoint_preintegration_top_test.sv */
// Self-checking testbench for the midpoint IMU preintegration block.
// Depends on mpi_pkg, mpi_in_if, mpi_out_if and the block's RTL.
`timescale 1ns / 1ps

module imu_midpoint_preintegration_top_test;

  typedef struct {
    logic               kind;
    logic signed [23:0] acc[3];
    logic signed [23:0] gyr[3];
  } sample_t;

  typedef logic signed [9:0][31:0] motion_t;

  class preint_scoreboard;
    longint accel_bias[3], gyro_bias[3], period;
    longint prev_acc[3], prev_gyr[3], pos[3], vel[3], quat[4];
    motion_t expected_q[$];
    int errors, checked, starts;

    function new();
      period = mpi_pkg::PERIOD_RESET;
      foreach (accel_bias[i]) begin
        accel_bias[i] = 0;
        gyro_bias[i] = 0;
        prev_acc[i] = 0;
        prev_gyr[i] = 0;
      end
      clear_motion();
    endfunction

    function void clear_motion();
      foreach (pos[i]) begin
        pos[i] = 0;
        vel[i] = 0;
      end
      quat[0] = longint'(mpi_pkg::Q30_ONE);
      quat[1] = 0;
      quat[2] = 0;
      quat[3] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] data);
      case (idx)
        mpi_pkg::CFG_ACCEL_BIAS_X: accel_bias[0] = longint'(signed'(data));
        mpi_pkg::CFG_ACCEL_BIAS_Y: accel_bias[1] = longint'(signed'(data));
        mpi_pkg::CFG_ACCEL_BIAS_Z: accel_bias[2] = longint'(signed'(data));
        mpi_pkg::CFG_GYRO_BIAS_X: gyro_bias[0] = longint'(signed'(data));
        mpi_pkg::CFG_GYRO_BIAS_Y: gyro_bias[1] = longint'(signed'(data));
        mpi_pkg::CFG_GYRO_BIAS_Z: gyro_bias[2] = longint'(signed'(data));
        mpi_pkg::CFG_SAMPLE_PERIOD: period = longint'({40'd0, data});
        default: ;
      endcase
    endfunction

    function longint round_sh(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint quat_term(longint a, longint b, longint c, longint d);
      return clip32(round_sh((a >>> 2) + (b >>> 2) + (c >>> 2) + (d >>> 2), 28));
    endfunction

    function void spin(input longint q[4], input longint v[3], output longint r[3]);
      longint t[3], c[3];
      t[0] = round_sh(q[2] * v[2] - q[3] * v[1], 29);
      t[1] = round_sh(q[3] * v[0] - q[1] * v[2], 29);
      t[2] = round_sh(q[1] * v[1] - q[2] * v[0], 29);
      c[0] = q[2] * t[2] - q[3] * t[1];
      c[1] = q[3] * t[0] - q[1] * t[2];
      c[2] = q[1] * t[1] - q[2] * t[0];
      for (int i = 0; i < 3; i++) r[i] = v[i] + round_sh(q[0] * t[i], 30) + round_sh(c[i], 30);
    endfunction

    function void note_request(sample_t s);
      longint h[3], nq[4], c0[3], c1[3], r0[3], r1[3], one, tt, t2, sum;
      motion_t m;
      if (s.kind == mpi_pkg::KIND_START) begin
        clear_motion();
        starts++;
      end else begin
        one = longint'(mpi_pkg::Q30_ONE);
        tt = period;
        for (int i = 0; i < 3; i++) begin
          h[i] = clip32(round_sh((((prev_gyr[i] + longint'(s.gyr[i])) >>> 1) - gyro_bias[i]) * tt,
                                 15));
          c0[i] = prev_acc[i] - accel_bias[i];
          c1[i] = longint'(s.acc[i]) - accel_bias[i];
        end
        nq[0] = quat_term(quat[0] * one, -(quat[1] * h[0]), -(quat[2] * h[1]), -(quat[3] * h[2]));
        nq[1] = quat_term(quat[0] * h[0], quat[1] * one, quat[2] * h[2], -(quat[3] * h[1]));
        nq[2] = quat_term(quat[0] * h[1], -(quat[1] * h[2]), quat[2] * one, quat[3] * h[0]);
        nq[3] = quat_term(quat[0] * h[2], quat[1] * h[1], -(quat[2] * h[0]), quat[3] * one);
        spin(quat, c0, r0);
        spin(nq, c1, r1);
        t2 = round_sh(tt * tt, 24);
        for (int i = 0; i < 3; i++) begin
          sum = r0[i] + r1[i];
          pos[i] = clip32(pos[i] + round_sh(vel[i] * tt, 24) + round_sh(t2 * sum, 26));
          vel[i] = clip32(vel[i] + round_sh(tt * sum, 25));
        end
        quat = nq;
      end
      for (int i = 0; i < 3; i++) begin
        prev_acc[i] = s.acc[i];
        prev_gyr[i] = s.gyr[i];
      end
      for (int i = 0; i < 3; i++) begin
        m[i] = pos[i][31:0];
        m[3 + i] = vel[i][31:0];
      end
      for (int i = 0; i < 4; i++) m[6 + i] = quat[i][31:0];
      expected_q = {expected_q, m};
    endfunction

    function void check_result(motion_t got);
      string names[10] = '{"pos_delta_x", "pos_delta_y", "pos_delta_z", "vel_delta_x",
                           "vel_delta_y", "vel_delta_z", "rot_w", "rot_x", "rot_y", "rot_z"};
      motion_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %0d with nothing pending", checked);
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < 10; i++) begin
        if (got[i] !== want[i]) begin
          errors++;
          if (errors <= 10) begin
            $display("result %0d %s: expected %0d, got %0d", checked, names[i],
                     signed'(want[i]), signed'(got[i]));
          end
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [23:0] cfg_data;
  logic idling_on;
  logic squeeze;
  int quiet_cycles;
  int sent;

  mpi_in_if in_chan();
  mpi_out_if out_chan();
  preint_scoreboard sb = new();

  imu_midpoint_preintegration_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan.sink),
    .out_chan(out_chan.source),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) begin
      sample_t s;
      s.kind = in_chan.kind;
      s.acc[0] = in_chan.accel_x;
      s.acc[1] = in_chan.accel_y;
      s.acc[2] = in_chan.accel_z;
      s.gyr[0] = in_chan.gyro_x;
      s.gyr[1] = in_chan.gyro_y;
      s.gyr[2] = in_chan.gyro_z;
      sb.note_request(s);
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      sb.check_result({out_chan.rot_z, out_chan.rot_y, out_chan.rot_x, out_chan.rot_w,
                       out_chan.vel_delta_z, out_chan.vel_delta_y, out_chan.vel_delta_x,
                       out_chan.pos_delta_z, out_chan.pos_delta_y, out_chan.pos_delta_x});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
        $display("watchdog: no request moved for %0d cycles", quiet_cycles);
        $display("imu_midpoint_preintegration_top_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze) begin
        out_chan.ready <= 1'b0;
        repeat (400) @(posedge clk);
        squeeze = 1'b0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic logic [23:0] pick24();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom);
      3: return 24'($urandom_range(0, 131071)) - 24'd65536;
      default: return 24'($urandom_range(0, 2097151)) - 24'd1048576;
    endcase
  endfunction

  task automatic send_sample(input logic kind, input logic [23:0] ax, ay, az, gx, gy, gz);
    int gap;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.kind <= kind;
    in_chan.accel_x <= ax;
    in_chan.accel_y <= ay;
    in_chan.accel_z <= az;
    in_chan.gyro_x <= gx;
    in_chan.gyro_y <= gy;
    in_chan.gyro_z <= gz;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_random(input int count);
    logic kind;
    for (int n = 0; n < count; n++) begin
      kind = ($urandom_range(0, 9) == 0) ? mpi_pkg::KIND_START : ~mpi_pkg::KIND_START;
      send_sample(kind, pick24(), pick24(), pick24(), pick24(), pick24(), pick24());
    end
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic write_all(input logic [23:0] ab, gb, per);
    write_reg(mpi_pkg::CFG_ACCEL_BIAS_X, ab);
    write_reg(mpi_pkg::CFG_ACCEL_BIAS_Y, -ab);
    write_reg(mpi_pkg::CFG_ACCEL_BIAS_Z, pick24());
    write_reg(mpi_pkg::CFG_GYRO_BIAS_X, gb);
    write_reg(mpi_pkg::CFG_GYRO_BIAS_Y, -gb);
    write_reg(mpi_pkg::CFG_GYRO_BIAS_Z, pick24());
    write_reg(mpi_pkg::CFG_SAMPLE_PERIOD, per);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= mpi_pkg::CFG_ACCEL_BIAS_X;
    cfg_data <= 24'd0;
    in_chan.valid <= 1'b0;
    in_chan.kind <= mpi_pkg::KIND_START;
    in_chan.accel_x <= 24'd0;
    in_chan.accel_y <= 24'd0;
    in_chan.accel_z <= 24'd0;
    in_chan.gyro_x <= 24'd0;
    in_chan.gyro_y <= 24'd0;
    in_chan.gyro_z <= 24'd0;
    idling_on = 1'b1;
    squeeze = 1'b0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Integration before any start uses the zero sample held since reset.
    send_sample(~mpi_pkg::KIND_START, 24'h010000, 24'h000000, 24'hFF0000, 24'h100000,
                24'h000000, 24'hF00000);
    send_sample(mpi_pkg::KIND_START, 24'h000000, 24'h000000, 24'h0A0000, 24'h000000,
                24'h000000, 24'h000000);
    send_sample(~mpi_pkg::KIND_START, 24'h000000, 24'h000000, 24'h0A0000, 24'h080000,
                24'h040000, 24'h020000);
    send_sample(~mpi_pkg::KIND_START, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                24'h7FFFFF, 24'h7FFFFF);
    send_sample(~mpi_pkg::KIND_START, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
                24'h800000, 24'h800000);
    send_sample(~mpi_pkg::KIND_START, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
                24'h7FFFFF, 24'h800000);
    send_sample(mpi_pkg::KIND_START, 24'h800000, 24'h7FFFFF, 24'h000000, 24'h000000,
                24'h7FFFFF, 24'h800000);
    send_sample(~mpi_pkg::KIND_START, 24'h555555, 24'hAAAAAA, 24'h000001, 24'hFFFFFF,
                24'h123456, 24'hEDCBA9);
    settle();

    // A zero period leaves the motion alone but still advances the previous sample.
    write_reg(mpi_pkg::CFG_SAMPLE_PERIOD, 24'd0);
    send_sample(~mpi_pkg::KIND_START, 24'h7FFFFF, 24'h000000, 24'h800000, 24'h7FFFFF,
                24'h800000, 24'h000000);
    send_sample(~mpi_pkg::KIND_START, 24'h000000, 24'h7FFFFF, 24'h000000, 24'h000000,
                24'h7FFFFF, 24'h7FFFFF);
    settle();

    // The longest period runs with extreme samples.
    write_all(24'h800000, 24'h7FFFFF, 24'hFFFFFF);
    for (int n = 0; n < 8; n++) begin
      send_sample(~mpi_pkg::KIND_START, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                  24'h7FFFFF, 24'h7FFFFF);
    end
    settle();

    write_all(24'h000000, 24'h000000, 24'd83886);
    send_random(90);
    squeeze = 1'b1;
    send_random(20);
    settle();
    write_all(24'h7FFFFF, 24'h800000, 24'd1);
    send_random(80);
    settle();
    write_all(pick24(), pick24(), 24'($urandom));
    send_random(80);
    settle();
    write_all(24'h001000, 24'hFFF000, 24'hFFFFFF);
    send_random(80);
    settle();
    idling_on = 1'b0;
    write_all(pick24(), pick24(), 24'd167772);
    send_random(80);
    settle();
    repeat (150) @(posedge clk);

    if (sb.expected_q.size() != 0) begin
      sb.errors += sb.expected_q.size();
      $display("%0d expected results never arrived", sb.expected_q.size());
    end
    $display("Run covered %0d samples (%0d interval starts) and %0d checked results,",
             sent, sb.starts, sb.checked);
    $display("over eight register settings including zero and full-scale periods.");
    if (sb.errors == 0) begin
      $display("imu_midpoint_preintegration_top_test: done, clean");
    end else begin
      $display("imu_midpoint_preintegration_top_test: done, errors");
    end
    $finish;
  end

endmodule
